>>> rtl/rsa_modular_exponentiation_macros.svh
// assertion macros for the checker file
`ifndef RSA_MODULAR_EXPONENTIATION_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_MACROS_SVH

// property checked only while out of reset
`define RME_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RME_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rme_pkg.sv
`default_nettype none
package rme_pkg;

  localparam int DATA_W    = 64;
  localparam int WIDTH_DEF = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd2;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] message;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              bad_modulus;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

>>> rtl/rsa_modular_exponentiation.sv
// flow: the message is reduced mod m, then for each exponent bit up to the top set bit
//   the running power is squared, after a multiply into the accumulator when the bit is set
// zero modulus or zero exponent: the result goes out without using the multiplier
// throughput: one item at a time, in_ready returns with out_valid unless the previous
//   result still waits; reset: synchronous active-low rst_n clears control and config
`default_nettype none
module rsa_modular_exponentiation #(
  parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rme_pkg::in_item_t             in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rme_pkg::out_item_t                 out_data,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rme_pkg::DATA_W-1:0]    cfg_data
);
  import rme_pkg::*;

  // configuration registers, only the low WIDTH bits matter
  logic [WIDTH-1:0] pub_exp_r, priv_exp_r, mod_cfg_r;

  // sequencer state and operands
  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;        // modulus latched per item
  logic [WIDTH-1:0] e_r, e_nxt;        // exponent bits left
  logic [WIDTH-1:0] acc_r, acc_nxt;    // accumulator
  logic [WIDTH-1:0] rp_r, rp_nxt;      // running power
  logic [WIDTH-1:0] res_r, res_nxt;    // finished result
  logic             bad_r, bad_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // shared multiplier hookup
  logic             mm_start, mm_done;
  logic [WIDTH-1:0] mm_a, mm_b, mm_p;

  // item fields cut to the working width
  logic [WIDTH-1:0] sel_exp, new_mod, one_mod;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_exp_r  <= '0;
      priv_exp_r <= '0;
      mod_cfg_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PUBLIC_EXP:  pub_exp_r  <= cfg_data[WIDTH-1:0];
        CFG_PRIVATE_EXP: priv_exp_r <= cfg_data[WIDTH-1:0];
        CFG_MODULUS:     mod_cfg_r  <= cfg_data[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_exp = (in_data.cmd == CMD_DECRYPT) ? priv_exp_r : pub_exp_r;
    new_mod = mod_cfg_r;
    // 1 mod m, zero when the modulus is one
    one_mod = (new_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
  end

  // sequencer: reduce the message, then multiply / square per exponent bit
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    rp_nxt        = rp_r;
    res_nxt       = res_r;
    bad_nxt       = bad_r;
    mm_start      = 1'b0;
    mm_a          = acc_r;
    mm_b          = rp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt   = new_mod;
          e_nxt   = sel_exp;
          bad_nxt = 1'b0;
          if (new_mod == '0) begin
            // zero modulus flags an error and returns 0
            res_nxt   = '0;
            bad_nxt   = 1'b1;
            acc_nxt   = '0;
            rp_nxt    = '0;
            e_nxt     = '0;
            state_nxt = ST_FINISH;
          end else if (sel_exp == '0) begin
            // zero exponent returns 1 even for modulus one
            res_nxt   = WIDTH'(1);
            state_nxt = ST_FINISH;
          end else begin
            // message mod m as message * (1 mod m)
            acc_nxt   = one_mod;
            mm_start  = 1'b1;
            mm_a      = in_data.message[WIDTH-1:0];
            mm_b      = one_mod;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          rp_nxt    = mm_p;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        mm_start = 1'b1;
        if (e_r[0]) begin
          mm_a      = acc_r;
          mm_b      = rp_r;
          state_nxt = ST_MUL;
        end else begin
          mm_a      = rp_r;
          mm_b      = rp_r;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_nxt   = mm_p;
          mm_start  = 1'b1;
          mm_a      = rp_r;
          mm_b      = rp_r;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          rp_nxt = mm_p;
          e_nxt  = e_r >> 1;
          if ((e_r >> 1) == '0) begin
            res_nxt   = acc_r;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_FINISH: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result      = DATA_W'(res_r);
          out_data_nxt.bad_modulus = bad_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      rp_r        <= '0;
      e_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      rp_r        <= rp_nxt;
      e_r         <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    res_r      <= res_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  rme_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mm_start),
    .a    (mm_a),
    .b    (mm_b),
    .m    (m_r),
    .done (mm_done),
    .p    (mm_p)
  );

endmodule
`default_nettype wire

>>> rtl/rme_mulmod.sv
`default_nettype none
// bit-serial interleaved modular multiplier, one bit of a per cycle, msb first
module rme_mulmod #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] m,
  output logic                  done,
  output logic      [WIDTH-1:0] p
);
  localparam int EW = WIDTH + 2;
  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] a_r, b_r, r_r;
  logic [WIDTH-1:0] a_nxt, b_nxt, r_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  logic [EW-1:0]    dbl, dbl_sub, sum, sum_sub;
  logic [WIDTH-1:0] r2, r3;

  always_comb begin
    // r = 2r mod m
    dbl     = {1'b0, r_r, 1'b0};
    dbl_sub = dbl - {2'b00, m};
    r2      = dbl_sub[EW-1] ? dbl[WIDTH-1:0] : dbl_sub[WIDTH-1:0];
    // r = r + b mod m when the current bit of a is set
    sum     = {2'b00, r2} + {2'b00, b_r};
    sum_sub = sum - {2'b00, m};
    if (a_r[WIDTH-1]) begin
      r3 = sum_sub[EW-1] ? sum[WIDTH-1:0] : sum_sub[WIDTH-1:0];
    end else begin
      r3 = r2;
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      r_nxt    = '0;
      cnt_nxt  = CW'(WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_nxt   = {a_r[WIDTH-2:0], 1'b0};
      r_nxt   = r3;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign p    = r_r;

endmodule
`default_nettype wire

>>> rtl/rme_sva.sv
`default_nettype none
`include "rsa_modular_exponentiation_macros.svh"
module rme_sva (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rme_pkg::out_item_t out_data
);
  import rme_pkg::*;

  // an accepted item keeps the block busy on the next cycle
  `RME_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "input accepted while still working")

  // a stalled result holds
  `RME_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed")

  // zero modulus error always comes with a zero result
  `RME_ASSERT(a_bad_zero, clk, rst_n, (out_valid && out_data.bad_modulus) |-> (out_data.result == '0), "bad modulus with nonzero result")

  // reset leaves the block idle with no result pending
  `RME_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!out_valid && in_ready), "not idle after reset")

endmodule

bind rsa_modular_exponentiation rme_sva u_rme_sva (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire

>>> bench/rsa_modular_exponentiation_test.sv
`default_nettype none
module rsa_modular_exponentiation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  typedef logic [DATA_W-1:0] word_t;

  // one pending register write on the cfg channel
  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    word_t                data;
  } reg_write_t;

  localparam int WIDTH = WIDTH_DEF;
  localparam word_t WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WIDTH);
  // index past the register list, the block drops writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // worst case for one item: full-width exponent with every bit set
  localparam int ITEM_LATENCY = 2 * WIDTH * (WIDTH + 3) + 16;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int RANDOM_ITEMS = 80;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t                cfg_data = '0;

  rsa_modular_exponentiation #(.WIDTH(WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // words waiting to be offered, register writes waiting, results predicted
  in_item_t   pending_words[$];
  reg_write_t reg_writes[$];
  out_item_t  expected_results[$];

  // our own copy of the key registers, updated on each cfg transfer
  word_t key_public  = '0;
  word_t key_private = '0;
  word_t key_modulus = '0;

  // when set, neither side idles; chosen per phase by the sequencer
  bit no_idle = 1'b0;

  int cycle_count = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int zero_mod_seen = 0;
  int regs_written = 0;
  int key_settings = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // exact (a * b) mod m at double width
  function automatic word_t mul_mod(word_t a, word_t b, word_t m);
    logic [2*DATA_W-1:0] wide;
    wide = (2*DATA_W)'(a) * (2*DATA_W)'(b);
    return DATA_W'(wide % (2*DATA_W)'(m));
  endfunction

  // expected result of one word under the current key registers
  function automatic out_item_t modexp_predict(in_item_t word);
    word_t     m, e, acc, pw;
    out_item_t r;
    m = key_modulus & WORD_MASK;
    e = ((word.cmd == CMD_DECRYPT) ? key_private : key_public) & WORD_MASK;
    r.bad_modulus = 1'b0;
    if (m == '0) begin
      // zero modulus: flag it, result forced to zero
      r.result = '0;
      r.bad_modulus = 1'b1;
    end else if (e == '0) begin
      // zero exponent gives one, even for modulus one
      r.result = word_t'(1);
    end else begin
      acc = word_t'(1) % m;
      pw = (word.message & WORD_MASK) % m;
      // right-to-left square and multiply
      while (e != '0) begin
        if (e[0]) acc = mul_mod(acc, pw, m);
        e = e >> 1;
        pw = mul_mod(pw, pw, m);
      end
      r.result = acc & WORD_MASK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", what);
  endtask

  // input driver: offers queued words, predicts each one on its transfer
  int in_gap = 0;
  always @(posedge clk) begin : drive_words
    logic moved;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      moved = in_valid && in_ready;
      if (moved) begin
        expected_results.push_back(modexp_predict(in_data));
        words_sent++;
      end
      if (in_valid && !moved) begin
        // hold valid and payload until the transfer
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // cfg driver: same scheme, and the key copy follows each transfer
  int cfg_gap = 0;
  always @(posedge clk) begin : drive_regs
    logic moved;
    reg_write_t next_write;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_gap <= 0;
    end else begin
      moved = cfg_valid && cfg_ready;
      if (moved) begin
        regs_written++;
        case (cfg_index)
          CFG_PUBLIC_EXP:  key_public = cfg_data;
          CFG_PRIVATE_EXP: key_private = cfg_data;
          CFG_MODULUS:     key_modulus = cfg_data;
          default: ;  // past the list, dropped
        endcase
      end
      if (cfg_valid && !moved) begin
        // hold
      end else if (cfg_gap != 0) begin
        cfg_gap <= cfg_gap - 1;
        cfg_valid <= 1'b0;
      end else if (reg_writes.size() != 0) begin
        next_write = reg_writes.pop_front();
        cfg_index <= next_write.index;
        cfg_data <= next_write.data;
        cfg_valid <= 1'b1;
        cfg_gap <= pick_gap();
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  int out_stall = 0;
  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.bad_modulus) zero_mod_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h bad_modulus %b",
                                    out_data.result, out_data.bad_modulus));
        end else begin
          want = expected_results.pop_front();
          if (out_data.result !== want.result)
            report_mismatch($sformatf("result %0d: expected %h, got %h",
                                      results_seen, want.result, out_data.result));
          if (out_data.bad_modulus !== want.bad_modulus)
            report_mismatch($sformatf("result %0d: bad_modulus expected %b, got %b",
                                      results_seen, want.bad_modulus,
                                      out_data.bad_modulus));
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
      end
    end
  end

  // everything queued has gone through and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0 ||
           reg_writes.size() != 0 || cfg_valid)
      @(negedge clk);
  endtask

  task automatic set_keys(input word_t pub, input word_t priv, input word_t modulus);
    reg_writes.push_back('{CFG_PUBLIC_EXP, pub});
    reg_writes.push_back('{CFG_PRIVATE_EXP, priv});
    reg_writes.push_back('{CFG_MODULUS, modulus});
    key_settings++;
    drain();
  endtask

  task automatic send(input logic cmd, input word_t message);
    pending_words.push_back('{cmd, message});
  endtask

  // exponent with a random bit length, mostly short to keep items quick
  function automatic word_t rand_exponent();
    int unsigned r, bits;
    word_t v;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (r < 8) return '0;
    if (r < 60) bits = $urandom_range(1, 16);
    else if (r < 85) bits = $urandom_range(17, 40);
    else bits = DATA_W;
    if (bits < DATA_W) v = v & ((word_t'(1) << bits) - word_t'(1));
    v[bits-1] = 1'b1;
    return v;
  endfunction

  function automatic word_t rand_modulus();
    int unsigned r;
    word_t v;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (r < 5) return '0;
    if (r < 10) return word_t'(1);
    if (r < 15) return '1;
    if (r < 40) return (v & 64'hFFFF) | word_t'(2);
    return v;
  endfunction

  // messages around the modulus edges, or anything at all
  function automatic word_t rand_message(word_t m);
    word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = word_t'(1);
      2: v = '1;
      3: v = m - word_t'(1);
      4: v = m;
      5: v = m + (v & 64'hFFFF);
      6: v = v & 64'hFFFF;
      default: ;
    endcase
    return v;
  endfunction

  initial begin : sequencer
    int random_sent;
    int count;
    word_t m;
    random_sent = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: zero modulus on both commands
    send(CMD_ENCRYPT, '0);
    send(CMD_DECRYPT, '1);
    drain();

    // modulus one: zero exponent still gives one, nonzero gives zero
    set_keys('0, word_t'(3), word_t'(1));
    send(CMD_ENCRYPT, word_t'(5));
    send(CMD_DECRYPT, '1);
    drain();

    // largest modulus, all-ones private exponent, message equal to modulus
    set_keys(word_t'(65537), '1, '1);
    send(CMD_ENCRYPT, '0);
    send(CMD_ENCRYPT, word_t'(1));
    send(CMD_DECRYPT, '1);
    send(CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
    send(CMD_ENCRYPT, word_t'(2));
    drain();

    // textbook key pair, round trip and messages at or above the modulus
    set_keys(word_t'(17), word_t'(2753), word_t'(3233));
    send(CMD_ENCRYPT, word_t'(65));
    send(CMD_DECRYPT, word_t'(2790));
    send(CMD_ENCRYPT, word_t'(3233));
    send(CMD_DECRYPT, word_t'(5000));
    drain();

    // zero public exponent, exponent one, modulus with its top bit set
    set_keys('0, word_t'(1), 64'h8000_0000_0000_001D);
    send(CMD_ENCRYPT, '1);
    send(CMD_DECRYPT, 64'h8000_0000_0000_0000);
    send(CMD_DECRYPT, 64'h8000_0000_0000_001C);
    drain();

    // write past the list must change nothing, then clear the modulus
    reg_writes.push_back('{CFG_UNUSED, '1});
    reg_writes.push_back('{CFG_MODULUS, '0});
    drain();
    send(CMD_ENCRYPT, {$urandom, $urandom});
    send(CMD_DECRYPT, {$urandom, $urandom});
    drain();

    // random key settings, each followed by a burst of words
    while (random_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      m = rand_modulus();
      if ($urandom_range(0, 4) == 0) reg_writes.push_back('{CFG_UNUSED, {$urandom, $urandom}});
      set_keys(rand_exponent(), rand_exponent(), m);
      count = $urandom_range(6, 12);
      repeat (count) send(1'($urandom_range(0, 1)), rand_message(m));
      random_sent += count;
      drain();
    end
    no_idle = 1'b0;

    // tail: nothing more may come out
    repeat (ITEM_LATENCY) @(posedge clk);

    $display("covered %0d exponentiations over %0d key settings, %0d with zero modulus",
             words_sent, key_settings, zero_mod_seen);
    $display("%0d register writes, %0d results checked, %0d cycles",
             regs_written, results_seen, cycle_count);
    if (mismatches == 0) begin
      $display("rsa_modular_exponentiation_test passed");
    end else begin
      $display("rsa_modular_exponentiation_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("rsa_modular_exponentiation_test failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/rme_pkg.sv
rtl/rme_mulmod.sv
rtl/rsa_modular_exponentiation.sv
rtl/rme_sva.sv
bench/rsa_modular_exponentiation_test.sv
